// ----- rtl/c8ic_pkg.sv -----
// ----------------------------------------------------------------------------
// CHIP-8 instruction core package
// Item types, modes, status codes and sizes shared by the core's files.
// ----------------------------------------------------------------------------
`default_nettype none
package c8ic_pkg;

   localparam int unsigned ADDR_W = 12;

   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_EXEC  = 2'd1,
      MODE_READ  = 2'd2,
      MODE_PIXEL = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_UNKNOWN = 2'd1,
      ST_HALTED  = 2'd2,
      ST_SPARE   = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [11:0] address;
      logic [7:0]  data;
      logic [7:0]  random_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] program_counter;
      logic [15:0] opcode;
      logic [7:0]  read_data;
      logic        display_changed;
   } rsp_type;

endpackage
`default_nettype wire

// ----- rtl/chip8_instruction_core.sv -----
// ----------------------------------------------------------------------------
// CHIP-8 instruction core
// Memory, registers, stack, timer and display of a CHIP-8 machine, one item
// at a time under a sequencer that shares one ALU and one memory port.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// req      in         start & !busy          req_type
// rsp      out        rsp_valid, one cycle   rsp_type
// csr      in         csr_valid & csr_ready  start address
// After reset a clearing pass zeroes memory and display; busy stays high
// during it. A load passes S_DONE and a read S_MEMRD before its result is
// registered. An instruction is fetched in S_FETCH1 and S_FETCH2, decoded in
// S_DECODE; FX33, FX55, FX65, 00E0 and DXYN with nonzero N use more states,
// set by the one memory port and one display port.
// The receiver cannot stall; each result shows for one cycle.
`default_nettype none
module chip8_instruction_core
   import c8ic_pkg::*;
#(
   parameter int MEM_BYTES   = 4096,
   parameter int STACK_DEPTH = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire req_type      req_item,
   output logic              rsp_valid,
   output rsp_type           rsp_item,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [11:0]  csr_start_address
);
   localparam int MW = $clog2(MEM_BYTES);
   localparam int SW = $clog2(STACK_DEPTH);
   localparam int PIXELS = 2048;
   localparam int CLRN = (MEM_BYTES > PIXELS) ? MEM_BYTES : PIXELS;
   localparam int CW = $clog2(CLRN) + 1;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_MEMRD, S_FETCH1, S_FETCH2, S_DECODE,
      S_SCLR, S_BCD, S_BCDW, S_STORE, S_LOAD1, S_LOAD2,
      S_DROW, S_DROW2, S_DPIX, S_DPIX2, S_DONE, S_PIXRD
   } state_type;

   state_type    state_ff, state_in;
   logic [11:0]  pc_ff, pc_in;
   logic [15:0]  i_ff, i_in, op_ff, op_in;
   logic [7:0]   v_ff [16];
   logic [7:0]   v_in [16];
   logic [11:0]  stk_ff [STACK_DEPTH];
   logic [11:0]  stk_in [STACK_DEPTH];
   logic [SW-1:0] sp_ff, sp_in;
   logic [7:0]   dt_ff, dt_in;
   logic         halt_ff, halt_in;
   req_type      req_ff, req_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [7:0]   bits_ff, bits_in, wk_ff, wk_in;
   logic [3:0]   hit_ff, hit_in;
   logic         hitb_ff, hitb_in;
   logic         chg_ff, chg_in;
   logic [1:0]   st_ff, st_in;
   logic         rv_ff, rv_in;
   rsp_type      rsp_ff, rsp_in;

   logic          m_we;
   logic [MW-1:0] m_wa, m_ra;
   logic [7:0]    m_wd, m_rd;
   logic          d_we;
   logic [10:0]   d_wa, d_ra;
   logic [0:0]    d_wd, d_rd;

   c8ic_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
      .clock(clock), .wr_en(m_we), .wr_addr(m_wa), .wr_data(m_wd),
      .rd_addr(m_ra), .rd_data(m_rd));
   c8ic_ram #(.WIDTH(1), .DEPTH(PIXELS)) u_disp (
      .clock(clock), .wr_en(d_we), .wr_addr(d_wa), .wr_data(d_wd),
      .rd_addr(d_ra), .rd_data(d_rd));

   logic [3:0]  ox, oy, on;
   logic [7:0]  vx, vy, nn;
   logic [11:0] nxt, skp;
   logic [8:0]  sum9;
   logic [15:0] iaddr;
   logic [5:0]  px;
   logic [4:0]  py;

   assign ox = op_ff[11:8];
   assign oy = op_ff[7:4];
   assign on = op_ff[3:0];
   assign nn = op_ff[7:0];
   assign vx = v_ff[ox];
   assign vy = v_ff[oy];
   assign nxt = pc_ff + 12'd2;
   assign skp = pc_ff + 12'd4;
   assign iaddr = i_ff + 16'(cnt_ff);
   assign px = 6'(vx + 8'(hit_ff[2:0]));
   assign py = 5'(vy + 8'(cnt_ff));

   assign busy = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) && !start;
   assign rsp_valid = rv_ff;
   assign rsp_item = rsp_ff;

   always_comb begin
      state_in = state_ff; pc_in = pc_ff; i_in = i_ff; op_in = op_ff;
      v_in = v_ff; stk_in = stk_ff; sp_in = sp_ff; dt_in = dt_ff;
      halt_in = halt_ff; req_in = req_ff; cnt_in = cnt_ff;
      bits_in = bits_ff; wk_in = wk_ff; hit_in = hit_ff; hitb_in = hitb_ff;
      chg_in = chg_ff; st_in = st_ff; rv_in = 1'b0; rsp_in = rsp_ff;
      m_we = 1'b0; m_wa = req_ff.address[MW-1:0]; m_wd = req_ff.data;
      m_ra = req_ff.address[MW-1:0];
      d_we = 1'b0; d_wa = 11'(cnt_ff); d_wd = 1'b0; d_ra = req_ff.address[10:0];
      sum9 = 9'd0;
      case (state_ff)
         S_CLEAR: begin
            m_we = (cnt_ff < CW'(MEM_BYTES));
            m_wa = cnt_ff[MW-1:0]; m_wd = 8'd0;
            d_we = (cnt_ff < CW'(PIXELS));
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(CLRN - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (csr_valid && !start) begin
               pc_in = csr_start_address;
            end
            if (start) begin
               req_in = req_item; chg_in = 1'b0; st_in = ST_OK; op_in = 16'd0;
               m_ra = req_item.address[MW-1:0];
               d_ra = req_item.address[10:0];
               case (mode_type'(req_item.mode))
                  MODE_LOAD: begin
                     m_we = 1'b1; m_wa = req_item.address[MW-1:0];
                     m_wd = req_item.data; state_in = S_DONE;
                  end
                  MODE_READ: state_in = S_MEMRD;
                  MODE_PIXEL: state_in = S_PIXRD;
                  default: begin
                     if (halt_ff) begin
                        st_in = ST_HALTED; state_in = S_DONE;
                     end else begin
                        m_ra = pc_ff[MW-1:0]; state_in = S_FETCH1;
                     end
                  end
               endcase
            end
         end
         S_MEMRD: begin
            rsp_in.read_data = m_rd; state_in = S_DONE; op_in = 16'd0;
            rv_in = 1'b1; state_in = S_IDLE;
            rsp_in.status = st_ff; rsp_in.program_counter = pc_ff;
            rsp_in.opcode = 16'd0; rsp_in.display_changed = 1'b0;
         end
         S_PIXRD: begin
            rv_in = 1'b1; state_in = S_IDLE;
            rsp_in.status = st_ff; rsp_in.program_counter = pc_ff;
            rsp_in.opcode = 16'd0; rsp_in.display_changed = 1'b0;
            rsp_in.read_data = req_ff.address[11] ? 8'd0 : {7'd0, d_rd[0]};
         end
         S_FETCH1: begin
            op_in[15:8] = m_rd;
            m_ra = MW'(pc_ff + 12'd1); state_in = S_FETCH2;
         end
         S_FETCH2: begin
            op_in[7:0] = m_rd; state_in = S_DECODE;
         end
         S_DECODE: begin
            state_in = S_DONE; pc_in = nxt; cnt_in = '0;
            case (op_ff[15:12])
               4'h0: begin
                  if (op_ff == 16'h00E0) begin
                     chg_in = 1'b1; state_in = S_SCLR;
                  end else if (op_ff == 16'h00EE) begin
                     sp_in = sp_ff - 1'b1;
                     pc_in = stk_ff[sp_ff - 1'b1] + 12'd2;
                  end else begin
                     pc_in = pc_ff; st_in = ST_UNKNOWN; halt_in = 1'b1;
                  end
               end
               4'h1: pc_in = op_ff[11:0];
               4'h2: begin
                  stk_in[sp_ff] = pc_ff; sp_in = sp_ff + 1'b1;
                  pc_in = op_ff[11:0];
               end
               4'h3: pc_in = (vx == nn) ? skp : nxt;
               4'h4: pc_in = (vx != nn) ? skp : nxt;
               4'h5: pc_in = (vx == vy) ? skp : nxt;
               4'h6: v_in[ox] = nn;
               4'h7: v_in[ox] = vx + nn;
               4'h8: begin
                  case (on)
                     4'h0: v_in[ox] = vy;
                     4'h1: v_in[ox] = vx | vy;
                     4'h2: v_in[ox] = vx & vy;
                     4'h3: v_in[ox] = vx ^ vy;
                     4'h4: begin
                        sum9 = {1'b0, vx} + {1'b0, vy};
                        v_in[ox] = sum9[7:0]; v_in[15] = {7'd0, sum9[8]};
                     end
                     4'h5: begin
                        v_in[ox] = vx - vy; v_in[15] = {7'd0, vx >= vy};
                     end
                     4'h6: begin
                        v_in[ox] = vx >> 1; v_in[15] = {7'd0, vx[0]};
                     end
                     4'h7: begin
                        v_in[ox] = vy - vx; v_in[15] = {7'd0, vy >= vx};
                     end
                     4'hE: begin
                        v_in[ox] = vx << 1; v_in[15] = {7'd0, vx[7]};
                     end
                     default: begin
                        pc_in = pc_ff; st_in = ST_UNKNOWN; halt_in = 1'b1;
                     end
                  endcase
               end
               4'h9: pc_in = (vx != vy) ? skp : nxt;
               4'hA: i_in = {4'd0, op_ff[11:0]};
               4'hB: pc_in = op_ff[11:0] + {4'd0, v_ff[0]};
               4'hC: v_in[ox] = req_ff.random_byte & nn;
               4'hD: begin
                  chg_in = 1'b1; hitb_in = 1'b0;
                  state_in = (on == 4'd0) ? S_DONE : S_DROW;
                  if (on == 4'd0) v_in[15] = 8'd0;
               end
               4'hE: pc_in = nxt;
               default: begin
                  case (nn)
                     8'h07: v_in[ox] = dt_ff;
                     8'h15: dt_in = vx;
                     8'h1E: i_in = i_ff + {8'd0, vx};
                     8'h29: i_in = {6'd0, vx, 2'd0} + {8'd0, vx};
                     8'h33: begin
                        wk_in = vx; bits_in = 8'd0; state_in = S_BCD;
                     end
                     8'h55: state_in = S_STORE;
                     8'h65: state_in = S_LOAD1;
                     default: begin
                        pc_in = pc_ff; st_in = ST_UNKNOWN; halt_in = 1'b1;
                     end
                  endcase
               end
            endcase
            if (halt_in == halt_ff && dt_in != 8'd0) dt_in = dt_in - 1'b1;
         end
         S_SCLR: begin
            d_we = 1'b1; d_wa = 11'(cnt_ff); d_wd = 1'b0;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(PIXELS - 1)) state_in = S_DONE;
         end
         S_BCD: begin
            // Digits found by repeated subtraction of 100 then 10.
            if (cnt_ff == CW'(0)) begin
               if (wk_ff >= 8'd100) begin
                  wk_in = wk_ff - 8'd100; bits_in = bits_ff + 1'b1;
               end else state_in = S_BCDW;
            end else if (cnt_ff == CW'(1)) begin
               if (wk_ff >= 8'd10) begin
                  wk_in = wk_ff - 8'd10; bits_in = bits_ff + 1'b1;
               end else state_in = S_BCDW;
            end else state_in = S_BCDW;
         end
         S_BCDW: begin
            m_we = 1'b1; m_wa = iaddr[MW-1:0];
            m_wd = (cnt_ff == CW'(2)) ? wk_ff : bits_ff;
            bits_in = 8'd0; cnt_in = cnt_ff + 1'b1;
            state_in = (cnt_ff == CW'(2)) ? S_DONE : S_BCD;
         end
         S_STORE: begin
            m_we = 1'b1; m_wa = iaddr[MW-1:0]; m_wd = v_ff[cnt_ff[3:0]];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[3:0] == ox) state_in = S_DONE;
         end
         S_LOAD1: begin
            m_ra = iaddr[MW-1:0]; state_in = S_LOAD2;
         end
         S_LOAD2: begin
            v_in[cnt_ff[3:0]] = m_rd; cnt_in = cnt_ff + 1'b1;
            state_in = (cnt_ff[3:0] == ox) ? S_DONE : S_LOAD1;
         end
         S_DROW: begin
            m_ra = iaddr[MW-1:0]; state_in = S_DROW2; hit_in = 4'd0;
         end
         S_DROW2: begin
            bits_in = m_rd; state_in = S_DPIX;
         end
         S_DPIX: begin
            // Each column: read the pixel, then, if the sprite bit is set, write it toggled.
            d_ra = {py, px};
            if (hit_ff[3]) begin
               cnt_in = cnt_ff + 1'b1;
               state_in = (cnt_ff[3:0] + 1'b1 == on) ? S_DONE : S_DROW;
               if (cnt_ff[3:0] + 1'b1 == on) v_in[15] = {7'd0, hitb_ff};
            end else if (bits_ff[3'd7 - hit_ff[2:0]]) begin
               state_in = S_DPIX2;
            end else hit_in = hit_ff + 1'b1;
         end
         S_DPIX2: begin
            d_we = 1'b1; d_wa = {py, px}; d_wd = ~d_rd;
            if (d_rd[0]) hitb_in = 1'b1;
            hit_in = hit_ff + 1'b1; state_in = S_DPIX;
         end
         S_DONE: begin
            rv_in = 1'b1; state_in = S_IDLE;
            rsp_in.status = st_ff; rsp_in.program_counter = pc_ff;
            rsp_in.opcode = op_ff; rsp_in.read_data = 8'd0;
            rsp_in.display_changed = chg_ff;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; pc_ff <= 12'h200;
         i_ff <= 16'd0; sp_ff <= '0; dt_ff <= 8'd0; halt_ff <= 1'b0;
         cnt_ff <= '0; rv_ff <= 1'b0;
         for (int k = 0; k < 16; k++) v_ff[k] <= 8'd0;
         for (int k = 0; k < STACK_DEPTH; k++) stk_ff[k] <= 12'd0;
      end else begin
         state_ff <= state_in; pc_ff <= pc_in; i_ff <= i_in;
         sp_ff <= sp_in; dt_ff <= dt_in;
         halt_ff <= halt_in; cnt_ff <= cnt_in; rv_ff <= rv_in;
         v_ff <= v_in; stk_ff <= stk_in;
      end
      op_ff <= op_in; req_ff <= req_in; bits_ff <= bits_in; wk_ff <= wk_in;
      hit_ff <= hit_in; hitb_ff <= hitb_in; chg_ff <= chg_in; st_ff <= st_in;
      rsp_ff <= rsp_in;
   end
endmodule
`default_nettype wire

// ----- rtl/c8ic_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module c8ic_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- rtl/chip8_instruction_core_checker.sv -----
// ----------------------------------------------------------------------------
// CHIP-8 instruction core checker
// Port-level checks on the request, result and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none
module chip8_instruction_core_checker
   import c8ic_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_item,
   input wire logic    csr_valid,
   input wire logic    csr_ready
);
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("item accepted without going busy");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while still busy");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result held over two cycles");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.status != ST_SPARE) else $error("bad status");
   a_csr: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !busy) else $error("register write offered while busy");
endmodule

bind chip8_instruction_core chip8_instruction_core_checker u_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_item(rsp_item),
   .csr_valid(csr_valid), .csr_ready(csr_ready));
`default_nettype wire

// ----- dv/chip8_instruction_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CHIP-8 instruction core testbench
// Loads short programs into the core and steps them with random content. A
// shadow machine in the testbench predicts every result. Loads, reads and
// pixel reads are mixed in, and the run ends with a halt on an unknown opcode.
// ----------------------------------------------------------------------------
module chip8_instruction_core_test;
   import c8ic_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;
   localparam logic [15:0] OP_CLS = 16'h00E0;
   localparam logic [15:0] OP_RET = 16'h00EE;
   localparam logic [3:0] ALU_MOV = 4'h0, ALU_OR = 4'h1, ALU_AND = 4'h2, ALU_XOR = 4'h3;
   localparam logic [3:0] ALU_ADD = 4'h4, ALU_SUB = 4'h5, ALU_SHR = 4'h6, ALU_SUBN = 4'h7;
   localparam logic [3:0] ALU_SHL = 4'hE;
   localparam logic [7:0] FX_GET_DT = 8'h07, FX_SET_DT = 8'h15, FX_ADD_I = 8'h1E;
   localparam logic [7:0] FX_FONT = 8'h29, FX_BCD = 8'h33, FX_STORE = 8'h55, FX_FETCH = 8'h65;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_item = '0;
   logic rsp_valid;
   rsp_type rsp_item;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [11:0] csr_start_address = 12'h200;

   chip8_instruction_core i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_start_address(csr_start_address)
   );

   // Shadow machine state.
   logic [7:0]  mem [4096];
   logic [7:0]  vreg [16];
   logic [11:0] stack [16];
   logic [3:0]  sp;
   logic [11:0] pc;
   logic [15:0] ireg;
   logic [7:0]  dtimer;
   bit          pixels [2048];
   bit          halted;

   req_type pending_items [$];
   rsp_type expected_results [$];
   int errors = 0;
   int cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic rsp_type step_machine(req_type r);
      rsp_type o;
      logic [15:0] op;
      logic [3:0] x, y, n;
      logic [7:0] nn, f, bits;
      logic [11:0] nnn, nxt, skp;
      logic [8:0] sum;
      logic [4:0] yy;
      logic [5:0] xx;
      bit bad, hit;
      o = '0;
      case (r.mode)
         MODE_LOAD: mem[r.address] = r.data;
         MODE_READ: o.read_data = mem[r.address];
         MODE_PIXEL: o.read_data = (r.address < 2048) ? 8'(pixels[r.address]) : 8'd0;
         default: begin
            if (halted) begin
               o.status = ST_HALTED;
            end else begin
               op = {mem[pc], mem[pc + 12'd1]};
               o.opcode = op;
               x = op[11:8];
               y = op[7:4];
               n = op[3:0];
               nn = op[7:0];
               nnn = op[11:0];
               nxt = pc + 12'd2;
               skp = pc + 12'd4;
               bad = 1'b0;
               case (op[15:12])
                  4'h0: begin
                     if (op == OP_CLS) begin
                        foreach (pixels[i]) pixels[i] = 1'b0;
                        o.display_changed = 1'b1;
                        pc = nxt;
                     end else if (op == OP_RET) begin
                        sp = sp - 4'd1;
                        pc = stack[sp] + 12'd2;
                     end else begin
                        bad = 1'b1;
                     end
                  end
                  4'h1: pc = nnn;
                  4'h2: begin
                     stack[sp] = pc;
                     sp = sp + 4'd1;
                     pc = nnn;
                  end
                  4'h3: pc = (vreg[x] == nn) ? skp : nxt;
                  4'h4: pc = (vreg[x] != nn) ? skp : nxt;
                  4'h5: pc = (vreg[x] == vreg[y]) ? skp : nxt;
                  4'h6: begin vreg[x] = nn; pc = nxt; end
                  4'h7: begin vreg[x] = vreg[x] + nn; pc = nxt; end
                  4'h8: begin
                     case (n)
                        ALU_MOV: vreg[x] = vreg[y];
                        ALU_OR: vreg[x] = vreg[x] | vreg[y];
                        ALU_AND: vreg[x] = vreg[x] & vreg[y];
                        ALU_XOR: vreg[x] = vreg[x] ^ vreg[y];
                        ALU_ADD: begin
                           sum = {1'b0, vreg[x]} + {1'b0, vreg[y]};
                           vreg[x] = sum[7:0];
                           vreg[15] = {7'd0, sum[8]};
                        end
                        ALU_SUB: begin
                           f = {7'd0, vreg[x] >= vreg[y]};
                           vreg[x] = vreg[x] - vreg[y];
                           vreg[15] = f;
                        end
                        ALU_SHR: begin
                           f = {7'd0, vreg[x][0]};
                           vreg[x] = vreg[x] >> 1;
                           vreg[15] = f;
                        end
                        ALU_SUBN: begin
                           f = {7'd0, vreg[y] >= vreg[x]};
                           vreg[x] = vreg[y] - vreg[x];
                           vreg[15] = f;
                        end
                        ALU_SHL: begin
                           f = {7'd0, vreg[x][7]};
                           vreg[x] = vreg[x] << 1;
                           vreg[15] = f;
                        end
                        default: bad = 1'b1;
                     endcase
                     if (!bad) pc = nxt;
                  end
                  4'h9: pc = (vreg[x] != vreg[y]) ? skp : nxt;
                  4'hA: begin ireg = {4'd0, nnn}; pc = nxt; end
                  4'hB: pc = nnn + {4'd0, vreg[0]};
                  4'hC: begin vreg[x] = r.random_byte & nn; pc = nxt; end
                  4'hD: begin
                     hit = 1'b0;
                     for (int rr = 0; rr < n; rr++) begin
                        bits = mem[ireg[11:0] + 12'(rr)];
                        yy = 5'(vreg[y] + 8'(rr));
                        for (int cc = 0; cc < 8; cc++) begin
                           if (bits[7 - cc]) begin
                              xx = 6'(vreg[x] + 8'(cc));
                              if (pixels[{yy, xx}]) hit = 1'b1;
                              pixels[{yy, xx}] = !pixels[{yy, xx}];
                           end
                        end
                     end
                     vreg[15] = {7'd0, hit};
                     o.display_changed = 1'b1;
                     pc = nxt;
                  end
                  4'hE: pc = nxt;
                  default: begin
                     case (nn)
                        FX_GET_DT: vreg[x] = dtimer;
                        FX_SET_DT: dtimer = vreg[x];
                        FX_ADD_I: ireg = ireg + {8'd0, vreg[x]};
                        FX_FONT: ireg = 16'(vreg[x]) * 16'd5;
                        FX_BCD: begin
                           mem[ireg[11:0]] = vreg[x] / 8'd100;
                           mem[ireg[11:0] + 12'd1] = (vreg[x] / 8'd10) % 8'd10;
                           mem[ireg[11:0] + 12'd2] = vreg[x] % 8'd10;
                        end
                        FX_STORE: for (int i = 0; i <= x; i++) mem[ireg[11:0] + 12'(i)] = vreg[i];
                        FX_FETCH: for (int i = 0; i <= x; i++) vreg[i] = mem[ireg[11:0] + 12'(i)];
                        default: bad = 1'b1;
                     endcase
                     if (!bad) pc = nxt;
                  end
               endcase
               if (bad) begin
                  halted = 1'b1;
                  o.status = ST_UNKNOWN;
               end else if (dtimer > 0) begin
                  dtimer = dtimer - 8'd1;
               end
            end
         end
      endcase
      o.program_counter = pc;
      return o;
   endfunction

   function automatic logic [15:0] random_opcode();
      logic [7:0] fx_codes [7] = '{FX_GET_DT, FX_SET_DT, FX_ADD_I, FX_FONT, FX_BCD,
                                   FX_STORE, FX_FETCH};
      logic [3:0] group;
      logic [11:0] low;
      int k;
      group = 4'($urandom_range(0, 15));
      low = 12'($urandom);
      case (group)
         4'h0: return ($urandom_range(0, 3) == 0) ? OP_CLS : OP_RET;
         4'h8: begin
            k = $urandom_range(0, 8);
            return {group, low[11:4], (k == 8) ? ALU_SHL : 4'(k)};
         end
         4'hD: return {group, low[11:4], ($urandom_range(0, 9) == 0) ? 4'hF : 4'($urandom_range(0, 4))};
         4'hF: return {group, low[11:8], fx_codes[$urandom_range(0, 6)]};
         default: return {group, low};
      endcase
   endfunction

   task automatic issue(mode_type m, logic [11:0] a, logic [7:0] d, logic [7:0] rnd);
      req_type r;
      r.mode = m;
      r.address = a;
      r.data = d;
      r.random_byte = rnd;
      pending_items.push_back(r);
      expected_results.push_back(step_machine(r));
   endtask

   task automatic run_opcode(logic [15:0] op);
      issue(MODE_LOAD, pc, op[15:8], 8'($urandom));
      issue(MODE_LOAD, pc + 12'd1, op[7:0], 8'($urandom));
      issue(MODE_EXEC, 12'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic wait_idle();
      while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_start_address(logic [11:0] a);
      wait_idle();
      csr_valid <= 1'b1;
      csr_start_address <= a;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      pc = a;
   endtask

   initial begin
      int pick;
      foreach (mem[i]) mem[i] = 8'd0;
      foreach (vreg[i]) vreg[i] = 8'd0;
      foreach (stack[i]) stack[i] = 12'd0;
      foreach (pixels[i]) pixels[i] = 1'b0;
      sp = 4'd0;
      pc = 12'h200;
      ireg = 16'd0;
      dtimer = 8'd0;
      halted = 1'b0;
      @(negedge reset);
      write_start_address(12'h200);

      issue(MODE_LOAD, 12'h000, 8'hFF, 8'h00);
      issue(MODE_LOAD, 12'hFFF, 8'h00, 8'hFF);
      issue(MODE_READ, 12'h000, 8'h00, 8'h00);
      issue(MODE_READ, 12'hFFF, 8'hFF, 8'hFF);
      run_opcode(16'h6AFF);
      run_opcode(16'h6B01);
      run_opcode(16'h8AB4);
      run_opcode(16'h8AB5);
      run_opcode(16'h8AB7);
      run_opcode(16'h8A0E);
      run_opcode(16'hA000);
      run_opcode(16'hD000);
      run_opcode(16'hDAB1);
      issue(MODE_PIXEL, 12'd2047, 8'h00, 8'h00);
      run_opcode(16'hDAB1);
      issue(MODE_PIXEL, 12'd2048, 8'h00, 8'h00);
      run_opcode(OP_CLS);

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_start_address(12'h000);
            1: write_start_address(12'hFFF);
            2: write_start_address(12'hFFE);
            default: write_start_address(12'($urandom));
         endcase
         for (int k = 0; k < 75; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
               run_opcode(random_opcode());
            end else if (pick < 85) begin
               issue(MODE_LOAD, 12'($urandom), 8'($urandom), 8'($urandom));
            end else if (pick < 93) begin
               issue(MODE_READ, 12'($urandom), 8'($urandom), 8'($urandom));
            end else begin
               issue(MODE_PIXEL, ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 2047)),
                     8'($urandom), 8'($urandom));
            end
         end
      end

      run_opcode(16'h812F);
      for (int k = 0; k < 12; k++) begin
         issue(mode_type'($urandom_range(0, 3)), 12'($urandom), 8'($urandom), 8'($urandom));
         issue(MODE_EXEC, 12'($urandom), 8'($urandom), 8'($urandom));
      end

      wait_idle();
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) void'(pending_items.pop_front());
         if (start && busy) begin
            start <= 1'b1;
         end else if (pending_items.size() != 0 &&
                      ((cycles > 5500 && cycles < 7500) || $urandom_range(0, 99) >= 24)) begin
            start <= 1'b1;
            req_item <= pending_items[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_item);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_item.status !== want.status ||
                rsp_item.program_counter !== want.program_counter ||
                rsp_item.opcode !== want.opcode ||
                rsp_item.read_data !== want.read_data ||
                rsp_item.display_changed !== want.display_changed) begin
               $display("%0t: expected st %0d pc %h op %h rd %h chg %b, got st %0d pc %h op %h rd %h chg %b",
                        $time, want.status, want.program_counter, want.opcode, want.read_data,
                        want.display_changed, rsp_item.status, rsp_item.program_counter,
                        rsp_item.opcode, rsp_item.read_data, rsp_item.display_changed);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule
